### rtl/core/packed_upper_triangular_matmul_assert.svh
// ----------------------------------------------------------------------------
// packed_upper_triangular_matmul_assert.svh
// Assertion macros used by the matmul checker file.
// ----------------------------------------------------------------------------
`ifndef PACKED_UPPER_TRIANGULAR_MATMUL_ASSERT_SVH
`define PACKED_UPPER_TRIANGULAR_MATMUL_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define PUTM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("putm assertion failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define PUTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("putm assertion failed");

`endif

### rtl/core/putm_pkg.sv
// ----------------------------------------------------------------------------
// putm_pkg
// Types, constants and an index helper for the packed triangular multiplier.
// ----------------------------------------------------------------------------
package putm_pkg;

  localparam int MATRIX_SIZE  = 8;
  localparam int PACKED_COUNT = (MATRIX_SIZE * (MATRIX_SIZE + 1)) / 2;

  localparam int ROW_W   = 3;   // row / column field width
  localparam int IDX_W   = 6;   // packed element index width
  localparam int ELEM_W  = 16;  // stored element width
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int SUM_W   = 35;  // product element width
  localparam int CMD_W   = 2;

  localparam int IN_DATA_W  = 24;  // index + value, padded to bytes
  localparam int OUT_DATA_W = 48;  // row + column + value, padded to bytes
  localparam int OUT_PAD_W  = OUT_DATA_W - SUM_W - 2 * ROW_W;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MATRIX_SIZE - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  // One multiply step issued by the sequencer.
  typedef struct packed {
    logic             valid;
    logic             first;   // first term of a product element
    logic             lastk;   // final term of a product element
    logic             zero;    // below the diagonal, force zero
    logic             final_e; // last element of the run
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [IDX_W-1:0] a_addr;
    logic [IDX_W-1:0] b_addr;
  } step_t;

  // Packed index of the first stored element of row r.
  function automatic logic [IDX_W-1:0] row_base(input logic [ROW_W-1:0] r);
    int rb;
    rb = (int'(r) * (2 * MATRIX_SIZE + 1 - int'(r))) >>> 1;
    return IDX_W'(rb);
  endfunction

endpackage

### rtl/core/putm_seq.sv
// ----------------------------------------------------------------------------
// putm_seq
// Walk (i, j, k) over the product and issue one store read pair per step.
// ----------------------------------------------------------------------------
module putm_seq import putm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,   // compute transfer accepted
  input  logic  admit,   // datapath can take a new product element
  output logic  idle,
  output step_t step
);

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_t;

  seq_state_t       state_r, state_nxt;
  logic [ROW_W-1:0] i_r, i_nxt;
  logic [ROW_W-1:0] j_r, j_nxt;
  logic [ROW_W-1:0] k_r, k_nxt;
  logic [ROW_W-1:0] a_off, b_off;
  logic             below, elem_start, elem_end, go;

  assign below      = (i_r > j_r);
  assign elem_start = below || (k_r == i_r);
  assign elem_end   = below || (k_r == j_r);
  assign go         = (state_r == SEQ_RUN) && (!elem_start || admit);
  assign idle       = (state_r == SEQ_IDLE);

  assign a_off = k_r - i_r;
  assign b_off = j_r - k_r;

  always_comb begin
    step         = '0;
    step.valid   = go;
    step.first   = elem_start;
    step.lastk   = elem_end;
    step.zero    = below;
    step.final_e = (i_r == LAST_ROW) && (j_r == LAST_ROW);
    step.row     = i_r;
    step.col     = j_r;
    if (!below) begin
      step.a_addr = row_base(i_r) + {{(IDX_W-ROW_W){1'b0}}, a_off};
      step.b_addr = row_base(k_r) + {{(IDX_W-ROW_W){1'b0}}, b_off};
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          state_nxt = SEQ_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      SEQ_RUN: begin
        if (go) begin
          if (!elem_end) begin
            k_nxt = k_r + 1'b1;
          end else if (j_r != LAST_ROW) begin
            j_nxt = j_r + 1'b1;
            k_nxt = i_r;
          end else if (i_r != LAST_ROW) begin
            i_nxt = i_r + 1'b1;
            j_nxt = '0;
            k_nxt = i_r + 1'b1;
          end else begin
            state_nxt = SEQ_IDLE;
          end
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

### rtl/core/packed_upper_triangular_matmul.sv
// ----------------------------------------------------------------------------
// packed_upper_triangular_matmul
// Product of two packed upper triangular matrices held in on-chip stores.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): tuser carries the command. Load A / load B write
//   one packed element (index in tdata[5:0], value in tdata[21:6]);
//   loads with an index past the packed range and the unused command are
//   dropped. A compute transfer starts a product run.
//   Output stream (out_*): one transfer per element of C in row-major
//   order (row, column, 35-bit signed value); tlast marks element (7,7).
//   Each store has a single read port, so the terms of an element are read
//   one per cycle; the read/multiply/accumulate pipeline is drained between
//   elements, so a new element is not started before the last one's result
//   has reached the output register and that register is free.
//   in_tready is low while a run is being issued; loads are taken again
//   as soon as the last element has been issued.
//   Reset clears control state only; the stores hold garbage until loaded.
//   A stall on out_tready holds the result and freezes the issue of the
//   next element; no result is lost.
// ----------------------------------------------------------------------------
module packed_upper_triangular_matmul import putm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [5:0] element_index, [21:6] element_value
  input  logic [CMD_W-1:0]      in_tuser,   // [1:0] command
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] row, [5:3] column, [40:6] product_value
  output logic                  out_tlast   // last
);

  // Input decode
  logic                     in_xfer;
  logic [IDX_W-1:0]         in_idx;
  logic [ELEM_W-1:0]        in_val;
  logic                     idx_ok;
  cmd_t                     in_cmd;

  assign in_xfer = in_tvalid && in_tready;
  assign in_idx  = in_tdata[IDX_W-1:0];
  assign in_val  = in_tdata[IDX_W +: ELEM_W];
  assign in_cmd  = cmd_t'(in_tuser);
  assign idx_ok  = (in_idx < IDX_W'(PACKED_COUNT));

  // Sequencer
  logic  seq_idle, seq_start, admit;
  step_t step;

  assign seq_start = in_xfer && (in_cmd == CMD_COMPUTE);
  assign in_tready = seq_idle;

  putm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seq_start),
    .admit (admit),
    .idle  (seq_idle),
    .step  (step)
  );

  // Element stores: one write port from the input channel, one read port
  // each driven by the sequencer.
  logic [ELEM_W-1:0]        mem_a_r [PACKED_COUNT];
  logic [ELEM_W-1:0]        mem_b_r [PACKED_COUNT];
  logic signed [ELEM_W-1:0] a_rd_r, b_rd_r;

  always_ff @(posedge clk) begin
    if (in_xfer && idx_ok && (in_cmd == CMD_LOAD_A)) begin
      mem_a_r[in_idx] <= in_val;
    end
    a_rd_r <= mem_a_r[step.a_addr];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && idx_ok && (in_cmd == CMD_LOAD_B)) begin
      mem_b_r[in_idx] <= in_val;
    end
    b_rd_r <= mem_b_r[step.b_addr];
  end

  // Pipeline: s1 = read data valid, s2 = product valid, then accumulate.
  step_t                    s1_r, s2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  acc_r, sum_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else begin
      s1_r <= step;
      s2_r <= s1_r;
    end
  end

  // Force zero below the diagonal; the read data is don't-care there.
  always_ff @(posedge clk) begin
    if (s1_r.zero) begin
      prod_r <= '0;
    end else begin
      prod_r <= a_rd_r * b_rd_r;
    end
  end

  assign sum_c = (s2_r.first ? SUM_W'(0) : acc_r) + SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (s2_r.valid) begin
      acc_r <= sum_c;
    end
  end

  // Output register
  logic                    out_valid_r;
  logic [ROW_W-1:0]        out_row_r, out_col_r;
  logic signed [SUM_W-1:0] out_val_r;
  logic                    out_last_r;
  logic                    out_load;

  assign out_load = s2_r.valid && s2_r.lastk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r  <= s2_r.row;
      out_col_r  <= s2_r.col;
      out_val_r  <= sum_c;
      out_last_r <= s2_r.final_e;
    end
  end

  // Start a new element only on an empty pipeline and a free output slot,
  // so its result can never collide with one still waiting.
  assign admit = !s1_r.valid && !s2_r.valid && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_val_r, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;

endmodule

### rtl/core/putm_checker.sv
// ----------------------------------------------------------------------------
// putm_checker
// Port-level checks on the matmul block, bound to the top level.
// ----------------------------------------------------------------------------
`include "packed_upper_triangular_matmul_assert.svh"

module putm_checker import putm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [CMD_W-1:0]      in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  logic [ROW_W-1:0] row, col;
  logic [SUM_W-1:0] val;

  assign row = out_tdata[ROW_W-1:0];
  assign col = out_tdata[2*ROW_W-1:ROW_W];
  assign val = out_tdata[2*ROW_W +: SUM_W];

  // Hold a stalled result.
  `PUTM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // A compute transfer closes the input for the next cycle.
  `PUTM_ASSERT_NEXT(a_compute_blocks_in, in_tvalid && in_tready && (in_tuser == CMD_COMPUTE),
    !in_tready)

  // A run in progress blocks new input until its final element is issued.
  `PUTM_ASSERT_NOW(a_run_blocks_in, out_tvalid && !out_tlast, !in_tready)

  // The flagged result is the bottom-right corner.
  `PUTM_ASSERT_NOW(a_last_corner, out_tvalid && out_tlast,
    (row == LAST_ROW) && (col == LAST_ROW))

  // Elements below the diagonal are zero.
  `PUTM_ASSERT_NOW(a_lower_zero, out_tvalid && (row > col), val == '0)

endmodule

bind packed_upper_triangular_matmul putm_checker u_putm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
